/* rtl/dqr_pkg.sv */
// Package for the reversible ring-buffer deque: request and status codes, transfer types.
package dqr_pkg;

  localparam logic [2:0] REQ_APPEND   = 3'd0;
  localparam logic [2:0] REQ_RM_FIRST = 3'd1;
  localparam logic [2:0] REQ_RM_LAST  = 3'd2;
  localparam logic [2:0] REQ_COUNT    = 3'd3;
  localparam logic [2:0] REQ_REVERSE  = 3'd4;
  localparam logic [2:0] REQ_LIST     = 3'd5;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  localparam int CNT_OUT_W = 6;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [31:0]   value_out;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 last;
  } out_item_t;

endpackage

/* rtl/dqr_ram.sv */
// Generic single-clock RAM, one write port and one read port with registered read data.
module dqr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/deque_with_reverse.sv */
// Top level of the reversible ring-buffer deque.
// A single-result request shows its result in the cycle after the start transfer.
// List of n entries: busy after the transfer while its reads are issued; the n results follow on
// consecutive cycles, through the RAM read register; one RAM read per cycle sets that rate.
// Other requests: one per cycle while busy is low. The receiver cannot stall; results are strobed once.
// Reset (rst_n low, synchronous): empty, head 0, normal order; store contents not cleared.
module deque_with_reverse #(
  parameter int DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dqr_pkg::in_item_t in_item,
  output logic              out_strobe,
  output dqr_pkg::out_item_t out_result
);
  import dqr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  logic          state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          res_vld_r, res_vld_nxt;
  out_item_t     res_r, res_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          rd_last_r, rd_last_nxt;

  logic          accept, full, empty, list_end;
  logic [AW-1:0] head_inc, head_dec, tail_slot, list_slot;
  logic [AW:0]   tail_sum, list_sum;
  logic [CW-1:0] list_off;
  logic [1:0]    sts;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   rdata;

  dqr_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_item.value_in),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy   = (state_r == ST_LIST);
  assign accept = start && !busy;
  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);

  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);

  assign tail_sum  = {1'b0, head_r} + (AW+1)'(count_r);
  assign tail_slot = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                  : AW'(tail_sum);

  assign list_off  = rev_r ? (count_r - CW'(1) - idx_r) : idx_r;
  assign list_sum  = {1'b0, head_r} + (AW+1)'(list_off);
  assign list_slot = (list_sum >= (AW+1)'(DEPTH)) ? AW'(list_sum - (AW+1)'(DEPTH))
                                                  : AW'(list_sum);
  assign list_end  = (idx_r == count_r - CW'(1));

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    rev_nxt     = rev_r;
    idx_nxt     = idx_r;
    res_vld_nxt = 1'b0;
    rd_pend_nxt = 1'b0;
    rd_last_nxt = rd_last_r;
    sts         = STS_OK;
    we          = 1'b0;
    waddr       = tail_slot;
    re          = 1'b0;
    raddr       = list_slot;
    if (state_r == ST_LIST) begin
      re          = 1'b1;
      rd_pend_nxt = 1'b1;
      rd_last_nxt = list_end;
      idx_nxt     = idx_r + CW'(1);
      if (list_end) begin
        state_nxt = ST_IDLE;
      end
    end else if (accept) begin
      res_vld_nxt = 1'b1;
      case (in_item.req_type)
        REQ_APPEND: begin
          if (full) begin
            sts = STS_FULL;
          end else begin
            we        = 1'b1;
            count_nxt = count_r + CW'(1);
            if (rev_r) begin
              head_nxt = head_dec;
              waddr    = head_dec;
            end
          end
        end
        REQ_RM_FIRST, REQ_RM_LAST: begin
          if (empty) begin
            sts = STS_EMPTY;
          end else begin
            count_nxt = count_r - CW'(1);
            if ((in_item.req_type == REQ_RM_FIRST) != rev_r) begin
              head_nxt = head_inc;
            end
          end
        end
        REQ_REVERSE: begin
          if (!empty) begin
            rev_nxt = !rev_r;
          end
        end
        REQ_LIST: begin
          if (empty) begin
            sts = STS_EMPTY;
          end else begin
            res_vld_nxt = 1'b0;
            state_nxt   = ST_LIST;
            idx_nxt     = '0;
          end
        end
        default: begin
        end
      endcase
    end
    res_nxt.status      = sts;
    res_nxt.value_out   = '0;
    res_nxt.entry_count = CNT_OUT_W'(count_nxt);
    res_nxt.last        = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      rev_r     <= 1'b0;
      idx_r     <= '0;
      res_vld_r <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      rev_r     <= rev_nxt;
      idx_r     <= idx_nxt;
      res_vld_r <= res_vld_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    rd_last_r <= rd_last_nxt;
  end

  assign out_strobe = res_vld_r || rd_pend_r;

  always_comb begin
    out_result = res_r;
    if (rd_pend_r) begin
      out_result.status      = STS_OK;
      out_result.value_out   = signed'(rdata);
      out_result.entry_count = CNT_OUT_W'(count_r);
      out_result.last        = rd_last_r;
    end
  end

endmodule

/* rtl/dqr_checker.sv */
// Port-level assertion checker for the deque, bound to the top level.
module dqr_checker #(
  parameter int DEPTH = 32
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input dqr_pkg::in_item_t  in_item,
  input logic               out_strobe,
  input dqr_pkg::out_item_t out_result
);
  import dqr_pkg::*;

  // busy only ever rises after a list transfer
  a_busy_from_list: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(busy) && busy |-> $past(start && in_item.req_type == REQ_LIST))
    else $error("busy rose without a list transfer");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && start && !busy && in_item.req_type != REQ_LIST |=> out_strobe && out_result.last)
    else $error("single-result request gave no final result next cycle");

  a_list_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_result.last |=> out_strobe)
    else $error("list results not contiguous");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result.status == STS_FULL |->
      out_result.entry_count == CNT_OUT_W'(DEPTH) && out_result.last)
    else $error("full status with wrong count");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result.status == STS_EMPTY |->
      out_result.entry_count == '0 && out_result.value_out == '0 && out_result.last)
    else $error("empty status with inconsistent result");

endmodule

bind deque_with_reverse dqr_checker #(.DEPTH(DEPTH)) u_dqr_checker (.*);
